// File: rtl/text_line_ending_cleanup_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line-ending cleanup unit
// Shared clocked-assertion forms; every check is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_ENDING_CLEANUP_UNIT_MACROS_SVH
`define TEXT_LINE_ENDING_CLEANUP_UNIT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define TLEC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true outside reset
`define TLEC_NEVER(label, cond, msg) \
  `TLEC_ASSERT(label, !(cond), msg)

`endif

// File: rtl/tlec_pkg.sv
// ----------------------------------------------------------------------------
// Line-ending cleanup package
// Byte codes, register indexes, state and transfer types shared by the unit.
// ----------------------------------------------------------------------------
package tlec_pkg;

  // Bundle queue depth (bundles of up to three output bytes)
  localparam int QueueDepth = 4;

  // Most output bytes one input item can cause
  localparam int MaxResults = 3;
  localparam int CountW     = 2;

  // Configuration index width
  localparam int CfgIndexW = 2;

  // Byte codes
  localparam logic [7:0] BYTE_CTRL_D  = 8'h04;
  localparam logic [7:0] BYTE_TAB     = 8'h09;
  localparam logic [7:0] BYTE_LF      = 8'h0A;
  localparam logic [7:0] BYTE_CR      = 8'h0D;
  localparam logic [7:0] BYTE_SUB     = 8'h1A;
  localparam logic [7:0] BYTE_SP      = 8'h20;
  localparam logic [7:0] BYTE_UPPER_A = 8'h41;
  localparam logic [7:0] BYTE_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_STRIP_LEADING = 2'd0,
    CFG_TO_LOWER      = 2'd1,
    CFG_HALF_NEWLINES = 2'd2,
    CFG_DOUBLE_SPACE  = 2'd3
  } cfg_index_t;

  // What the front end is holding back
  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_CR     = 2'd1,
    MODE_Z      = 2'd2
  } pend_mode_t;

  typedef struct packed {
    logic strip_leading;
    logic to_lower;
    logic half_newlines;
    logic double_space;
  } cfg_regs_t;

  typedef struct packed {
    pend_mode_t pending_mode;
    logic       at_line_start;
    logic       newline_toggle;
    logic       last_was_regular;
  } front_state_t;

  localparam front_state_t FRONT_STATE_RESET = '{
    pending_mode:     MODE_SEARCH,
    at_line_start:    1'b1,
    newline_toggle:   1'b0,
    last_was_regular: 1'b0
  };

  // Output bytes of one input item; bytes[0] goes out first
  typedef struct packed {
    logic [CountW-1:0]           cnt;
    logic [MaxResults-1:0][7:0]  bytes;
  } bundle_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

endpackage

// File: rtl/tlec_front.sv
// ----------------------------------------------------------------------------
// Line-ending cleanup front end
// Accepts one byte per cycle while the queue is not full, tracks line state and builds the output bundle.
// ----------------------------------------------------------------------------
module tlec_front import tlec_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_regs_t    cfg,
  input  logic         in_valid,
  output logic         in_ready,
  input  in_item_t     in_data,
  input  logic         q_full,
  output logic         push_valid,
  output bundle_t      push_data,
  output front_state_t state
);

  front_state_t st;
  front_state_t st_next;
  logic         accept;
  logic         pre_en;
  logic         main_en;
  logic         dbl_en;
  logic [7:0]   pre_byte;
  logic [7:0]   main_byte;
  logic [7:0]   b;
  logic         is_blank;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.in_byte;
  assign is_blank = (b == BYTE_SP) || (b == BYTE_TAB);

  // Classify the byte: optional held-back byte, main byte, extra LF
  always_comb begin
    st_next   = st;
    pre_en    = 1'b0;
    pre_byte  = BYTE_LF;
    main_en   = 1'b0;
    main_byte = BYTE_LF;
    dbl_en    = 1'b0;
    if (in_data.end_of_text) begin
      main_en = (st.pending_mode == MODE_CR) || st.last_was_regular;
      st_next = FRONT_STATE_RESET;
    end else if (b == BYTE_CTRL_D) begin
      st_next = st;
    end else begin
      st_next.last_was_regular = 1'b0;
      if (b == BYTE_LF) begin
        st_next.at_line_start = 1'b1;
        pre_en   = (st.pending_mode == MODE_Z);
        pre_byte = BYTE_SUB;
        st_next.pending_mode = MODE_SEARCH;
        if (!st.newline_toggle || !cfg.half_newlines) begin
          main_en = 1'b1;
          dbl_en  = cfg.double_space;
        end
        st_next.newline_toggle = !st.newline_toggle;
      end else if (b == BYTE_CR) begin
        st_next.at_line_start  = 1'b1;
        st_next.newline_toggle = 1'b0;
        pre_en   = (st.pending_mode == MODE_Z) || (st.pending_mode == MODE_CR);
        pre_byte = (st.pending_mode == MODE_Z) ? BYTE_SUB : BYTE_LF;
        st_next.pending_mode = MODE_CR;
      end else if (b == BYTE_SUB) begin
        st_next.newline_toggle = 1'b0;
        pre_en   = (st.pending_mode == MODE_CR);
        pre_byte = BYTE_LF;
        st_next.pending_mode = MODE_Z;
      end else if (is_blank && cfg.strip_leading && st.at_line_start) begin
        // leading blank dropped; pending byte stays pending
        st_next.last_was_regular = 1'b0;
      end else begin
        st_next.at_line_start    = 1'b0;
        st_next.newline_toggle   = 1'b0;
        st_next.last_was_regular = 1'b1;
        pre_en   = (st.pending_mode == MODE_Z) || (st.pending_mode == MODE_CR);
        pre_byte = (st.pending_mode == MODE_Z) ? BYTE_SUB : BYTE_LF;
        st_next.pending_mode = MODE_SEARCH;
        main_en  = 1'b1;
        if (cfg.to_lower && (b >= BYTE_UPPER_A) && (b <= BYTE_UPPER_Z)) begin
          main_byte = b + CASE_OFFSET;
        end else begin
          main_byte = b;
        end
      end
    end
  end

  // Pack the enabled bytes in order; the extra LF only follows a main LF
  always_comb begin
    push_data.cnt = {1'b0, pre_en} + {1'b0, main_en} + {1'b0, dbl_en};
    push_data.bytes[0] = pre_en ? pre_byte : (main_en ? main_byte : BYTE_LF);
    push_data.bytes[1] = (pre_en && main_en) ? main_byte : BYTE_LF;
    push_data.bytes[2] = BYTE_LF;
  end

  assign push_valid = accept && (push_data.cnt != '0);
  assign state      = st;

  // Line state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= FRONT_STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

// File: rtl/tlec_queue.sv
// ----------------------------------------------------------------------------
// Line-ending cleanup bundle queue
// Small FIFO of output bundles between the front and back ends.
// ----------------------------------------------------------------------------
module tlec_queue import tlec_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output bundle_t head_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  bundle_t         mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/tlec_back.sv
// ----------------------------------------------------------------------------
// Line-ending cleanup back end
// Serializes queued bundles into an output register, one byte per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module tlec_back import tlec_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  bundle_t   head_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [CountW-1:0] idx;
  logic              load;
  logic              is_last;

  assign load    = head_valid && (!out_valid || out_ready);
  assign is_last = (idx == head_data.cnt - 1'b1);
  assign pop     = load && is_last;

  // Byte index within the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= is_last ? '0 : idx + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte    <= head_data.bytes[idx];
      out_data.last_of_run <= is_last;
    end
  end

endmodule

// File: rtl/text_line_ending_cleanup_unit.sv
// ----------------------------------------------------------------------------
// Text line-ending cleanup unit
// CR/CR-LF to LF conversion with control-D/control-Z handling and options.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid / in_ready    | in_data (in_byte, end_of_text)
//  out     | output    | out_valid / out_ready  | out_data (out_byte, last_of_run)
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One input byte per cycle while the bundle queue (QUEUE_DEPTH entries) has room.
// The back end sends one output byte per cycle while out_ready is high; an item
// with 2 or 3 result bytes holds it until all of them have gone out. The first
// output byte is written to the bundle queue, then to the output register.
// Synchronous reset clears config, line state, queue and the output valid flag.
// Output stalls back up through the queue, then drop in_ready.
// ----------------------------------------------------------------------------
module text_line_ending_cleanup_unit import tlec_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic                 cfg_data
);

`include "text_line_ending_cleanup_unit_macros.svh"

  cfg_regs_t    cfg;
  logic         q_full;
  logic         push_valid;
  bundle_t      push_data;
  logic         pop;
  logic         head_valid;
  bundle_t      head_data;
  front_state_t front_st;
  logic         eot_xfer;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STRIP_LEADING: cfg.strip_leading <= cfg_data;
        CFG_TO_LOWER:      cfg.to_lower      <= cfg_data;
        CFG_HALF_NEWLINES: cfg.half_newlines <= cfg_data;
        CFG_DOUBLE_SPACE:  cfg.double_space  <= cfg_data;
        default:           cfg               <= cfg;
      endcase
    end
  end

  tlec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_data  (push_data),
    .state      (front_st)
  );

  tlec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  tlec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign eot_xfer = in_valid && in_ready && in_data.end_of_text;

  // A bundle carries at least one byte, and only non-empty queues are popped
  `TLEC_NEVER(a_push_empty_bundle, push_valid && (push_data.cnt == '0), "empty bundle pushed")
  `TLEC_NEVER(a_pop_empty_queue, pop && !head_valid, "pop from empty queue")
  // End of text returns the line state to its reset values
  `TLEC_ASSERT(a_eot_clears_state, eot_xfer |=> (front_st == FRONT_STATE_RESET), "state kept")

endmodule
